// ===== hdl/mac_address_text_parser_assert.svh =====
// assertion macros for the mac address text parser checker
// depends on nothing; included by the checker file only
`ifndef MAC_ADDRESS_TEXT_PARSER_ASSERT_SVH
`define MAC_ADDRESS_TEXT_PARSER_ASSERT_SVH

// same-cycle implication, disabled while reset is high
`define MACTP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mactp check failed");

// next-cycle implication, disabled while reset is high
`define MACTP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mactp check failed");

`endif

// ===== hdl/mactp_pkg.sv =====
// shared types and constants of the mac address text parser
// depends on nothing; imported by every module of the block
package mactp_pkg;

   localparam int ADDR_W      = 48;
   localparam int OCTET_IDX_W = 3;
   localparam int DIGITS_W    = 2;
   localparam int NIBBLE_W    = 4;
   localparam int CHAR_W      = 8;

   localparam logic [CHAR_W-1:0]   SEPARATOR    = 8'h3A;
   localparam logic [DIGITS_W-1:0] DIGITS_NONE  = 2'd0;
   localparam logic [DIGITS_W-1:0] DIGITS_ONE   = 2'd1;
   localparam logic [DIGITS_W-1:0] DIGITS_TWO   = 2'd2;

   // what one character is
   typedef struct packed {
      logic                is_hex;
      logic                is_colon;
      logic [NIBBLE_W-1:0] nibble;
   } char_class_type;

   // parse state carried between characters
   typedef struct packed {
      logic [OCTET_IDX_W-1:0] octet_index;
      logic [DIGITS_W-1:0]    digits_in_octet;
      logic [ADDR_W-1:0]      address_accumulator;
      logic                   failed;
   } parse_state_type;

endpackage

// ===== hdl/mactp_if.sv =====
// valid/ready channel interfaces for request and response beats
// depends on mactp_pkg for field widths
interface mactp_req_if import mactp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] character;
   logic              is_final;

   modport source (output valid, output character, output is_final, input ready);
   modport sink   (input valid, input character, input is_final, output ready);
endinterface

interface mactp_rsp_if import mactp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              success;
   logic [ADDR_W-1:0] address;

   modport source (output valid, output success, output address, input ready);
   modport sink   (input valid, input success, input address, output ready);
endinterface

// ===== hdl/mactp_char_class.sv =====
// character classifier: hex digit of either case, colon, or other
// depends on mactp_pkg
module mactp_char_class import mactp_pkg::*; (
   input  logic [CHAR_W-1:0] character,
   output char_class_type    char_class
);

   logic [CHAR_W-1:0] offset;

   // decode digit ranges and nibble value
   always_comb begin
      char_class.is_hex   = 1'b0;
      char_class.is_colon = (character == SEPARATOR);
      offset              = '0;
      if (character >= 8'h30 && character <= 8'h39) begin
         char_class.is_hex = 1'b1;
         offset            = character - 8'h30;
      end else if (character >= 8'h41 && character <= 8'h46) begin
         char_class.is_hex = 1'b1;
         offset            = character - 8'h37;
      end else if (character >= 8'h61 && character <= 8'h66) begin
         char_class.is_hex = 1'b1;
         offset            = character - 8'h57;
      end
      char_class.nibble = offset[NIBBLE_W-1:0];
   end

endmodule

// ===== hdl/mactp_step.sv =====
// next parse state for one character, plus the verdict if it ends the text
// depends on mactp_pkg
module mactp_step import mactp_pkg::*; #(
   parameter int OCTET_COUNT = 6
) (
   input  parse_state_type   state,
   input  char_class_type    char_class,
   output parse_state_type   state_next,
   output logic              success,
   output logic [ADDR_W-1:0] address
);

   localparam logic [OCTET_IDX_W-1:0] LAST_IDX = OCTET_IDX_W'(OCTET_COUNT - 1);

   // per-character update, nothing changes once failed
   always_comb begin
      state_next = state;
      if (!state.failed) begin
         if (char_class.is_hex) begin
            case (state.digits_in_octet)
               DIGITS_NONE: begin
                  state_next.address_accumulator =
                     {state.address_accumulator[ADDR_W-9:0], 4'h0, char_class.nibble};
                  state_next.digits_in_octet = DIGITS_ONE;
               end
               DIGITS_ONE: begin
                  state_next.address_accumulator =
                     {state.address_accumulator[ADDR_W-1:8],
                      state.address_accumulator[3:0], char_class.nibble};
                  state_next.digits_in_octet = DIGITS_TWO;
               end
               default: state_next.failed = 1'b1;
            endcase
         end else if (char_class.is_colon) begin
            if (state.digits_in_octet == DIGITS_NONE || state.octet_index >= LAST_IDX) begin
               state_next.failed = 1'b1;
            end else begin
               state_next.octet_index     = state.octet_index + 1'b1;
               state_next.digits_in_octet = DIGITS_NONE;
            end
         end else begin
            state_next.failed = 1'b1;
         end
      end
   end

   // verdict on the updated state
   assign success = !state_next.failed && state_next.digits_in_octet != DIGITS_NONE
                    && state_next.octet_index == LAST_IDX;
   assign address = success ? state_next.address_accumulator : '0;

endmodule

// ===== hdl/mac_address_text_parser.sv =====
// The parser takes one text character per beat on req_ch and, on the beat marked
// is_final, gives one response on rsp_ch with success and the 48-bit address
// (first octet most significant, zero when the text is not a valid address of
// OCTET_COUNT colon-separated octets of one or two hex digits). One character is
// taken every clock cycle; the response shows on rsp_ch the cycle after its final
// character. The single response register sets the rate: req_ch stalls only in reset or
// while that register holds a response that rsp_ch has not taken. Depends on mactp_pkg,
// the channel interfaces, mactp_char_class and mactp_step.
module mac_address_text_parser import mactp_pkg::*; #(
   parameter int OCTET_COUNT = 6
) (
   input  logic         clock,
   input  logic         reset,
   mactp_req_if.sink    req_ch,
   mactp_rsp_if.source  rsp_ch
);

   parse_state_type   state_ff, state_in, state_step;
   char_class_type    char_class;
   logic              step_success;
   logic [ADDR_W-1:0] step_address;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_success_ff, rsp_success_in;
   logic [ADDR_W-1:0] rsp_address_ff, rsp_address_in;
   logic              req_beat;

   mactp_char_class u_char_class (
      .character  (req_ch.character),
      .char_class (char_class)
   );

   mactp_step #(.OCTET_COUNT(OCTET_COUNT)) u_step (
      .state      (state_ff),
      .char_class (char_class),
      .state_next (state_step),
      .success    (step_success),
      .address    (step_address)
   );

   // take a beat whenever the response register is free or being drained
   assign req_ch.ready = !reset && (!rsp_valid_ff || rsp_ch.ready);
   assign req_beat     = req_ch.valid && req_ch.ready;

   // state and response register next values
   always_comb begin
      state_in       = state_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_success_in = rsp_success_ff;
      rsp_address_in = rsp_address_ff;
      if (req_beat) begin
         if (req_ch.is_final) begin
            state_in       = '0;
            rsp_valid_in   = 1'b1;
            rsp_success_in = step_success;
            rsp_address_in = step_address;
         end else begin
            state_in = state_step;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      rsp_success_ff <= rsp_success_in;
      rsp_address_ff <= rsp_address_in;
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.success = rsp_success_ff;
   assign rsp_ch.address = rsp_address_ff;

endmodule

// ===== hdl/mactp_checker.sv =====
// port-level checks for the mac address text parser, bound to the top level
// depends on mactp_pkg and mac_address_text_parser_assert.svh
`include "mac_address_text_parser_assert.svh"

module mactp_checker import mactp_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              req_is_final,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic              rsp_success,
   input logic [ADDR_W-1:0] rsp_address
);

   logic req_beat;
   logic rsp_beat;

   assign req_beat = req_valid && req_ready;
   assign rsp_beat = rsp_valid && rsp_ready;

   // a stalled response holds
   `MACTP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_success) && $stable(rsp_address))
   // a failed parse reports a zero address
   `MACTP_ASSERT_NOW(a_fail_zero, clock, reset, rsp_valid && !rsp_success,
      rsp_address == '0)
   // a response only rises after a final character beat
   `MACTP_ASSERT_NOW(a_rsp_from_final, clock, reset, $rose(rsp_valid),
      $past(req_beat && req_is_final))
   // a middle character never creates or drops a response
   `MACTP_ASSERT_NEXT(a_mid_quiet, clock, reset, req_beat && !req_is_final && !rsp_beat,
      rsp_valid == $past(rsp_valid))

endmodule

bind mac_address_text_parser mactp_checker u_mactp_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .req_is_final (req_ch.is_final),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_success  (rsp_ch.success),
   .rsp_address  (rsp_ch.address)
);
